// ----- hw/rtl/psp_pkg.sv -----
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types and constants for the planar shadow projection block.
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // APB data and address layout follow the coordinate width
  localparam int ApbDataW = (COORD_WIDTH > 32) ? 64 : 32;
  localparam int AddrLsb  = (COORD_WIDTH > 32) ? 3 : 2;
  localparam int RegIdxW  = 3;
  localparam int AddrW    = AddrLsb + RegIdxW;

  // light vector and divider numerator carry one extra bit
  localparam int DW       = COORD_WIDTH + 1;
  localparam int DvdW     = DW + FRAC_BITS;
  localparam int DivSteps = DvdW;
  localparam int CntW     = $clog2(DivSteps);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t CoordMax    = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CoordMin    = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t LightYReset = ~coord_t'((64'd1 << FRAC_BITS) - 64'd1);

  typedef enum logic [RegIdxW-1:0] {
    REG_LIGHT_X     = 3'd0,
    REG_LIGHT_Y     = 3'd1,
    REG_LIGHT_Z     = 3'd2,
    REG_DIRECTIONAL = 3'd3,
    REG_GROUND      = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_PREP   = 3'd1,
    ST_DIV    = 3'd2,
    ST_SAT    = 3'd3,
    ST_MUL    = 3'd4,
    ST_ACC    = 3'd5,
    ST_FINISH = 3'd6
  } state_e;

  typedef struct packed {
    coord_t vertex_x;
    coord_t vertex_y;
    coord_t vertex_z;
    logic   last_vertex;
  } vertex_t;

  typedef struct packed {
    coord_t shadow_x;
    coord_t shadow_y;
    coord_t shadow_z;
    coord_t bound_min_x;
    coord_t bound_max_x;
    coord_t bound_min_z;
    coord_t bound_max_z;
    logic   divide_fault;
    logic   mesh_done;
  } result_t;

  typedef struct packed {
    coord_t light_x;
    coord_t light_y;
    coord_t light_z;
    logic   directional_mode;
    coord_t ground_level;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  div_init;
    logic  div_step;
    logic  sat;
    logic  mul;
    logic  acc;
    logic  finish;
    axis_e axis;
  } psp_cmd_t;

  typedef struct packed {
    logic den_zero;
  } psp_status_t;

endpackage

// ----- hw/rtl/psp_cfg.sv -----
// ----------------------------------------------------------------------------
// psp_cfg
// APB register file holding the light and ground plane settings.
// ----------------------------------------------------------------------------
module psp_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [psp_pkg::AddrW-1:0]   paddr,
  input  logic [psp_pkg::ApbDataW-1:0] pwdata,
  output logic [psp_pkg::ApbDataW-1:0] prdata,
  output logic                        pready,
  output psp_pkg::cfg_t               cfg_o
);
  import psp_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;
  coord_t   wval;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:AddrLsb]);
  assign wr_en  = psel && penable && pwrite;
  assign wval   = pwdata[COORD_WIDTH-1:0];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_x          <= '0;
      cfg_q.light_y          <= LightYReset;
      cfg_q.light_z          <= '0;
      cfg_q.directional_mode <= 1'b1;
      cfg_q.ground_level     <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_LIGHT_X:     cfg_q.light_x          <= wval;
        REG_LIGHT_Y:     cfg_q.light_y          <= wval;
        REG_LIGHT_Z:     cfg_q.light_z          <= wval;
        REG_DIRECTIONAL: cfg_q.directional_mode <= pwdata[0];
        REG_GROUND:      cfg_q.ground_level     <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_LIGHT_X:     prdata = ApbDataW'($unsigned(cfg_q.light_x));
      REG_LIGHT_Y:     prdata = ApbDataW'($unsigned(cfg_q.light_y));
      REG_LIGHT_Z:     prdata = ApbDataW'($unsigned(cfg_q.light_z));
      REG_DIRECTIONAL: prdata = ApbDataW'(cfg_q.directional_mode);
      REG_GROUND:      prdata = ApbDataW'($unsigned(cfg_q.ground_level));
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/psp_ctrl.sv -----
// ----------------------------------------------------------------------------
// psp_ctrl
// Sequencer: divider iterations, shared multiplier passes, result hand-off.
// ----------------------------------------------------------------------------
module psp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  psp_pkg::psp_status_t status_i,
  output psp_pkg::psp_cmd_t    cmd_o
);
  import psp_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  axis_e           axis_q, axis_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  // output register can take a new transaction this cycle
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      axis_q      <= AXIS_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    axis_d     = axis_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.axis = axis_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = status_i.den_zero ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          state_d = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd_o.sat = 1'b1;
        axis_d    = AXIS_X;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        case (axis_q)
          AXIS_X: begin
            axis_d  = AXIS_Y;
            state_d = ST_MUL;
          end
          AXIS_Y: begin
            axis_d  = AXIS_Z;
            state_d = ST_MUL;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

// ----- hw/rtl/psp_dp.sv -----
// ----------------------------------------------------------------------------
// psp_dp
// Datapath: light vector, bit-serial divider, shared multiplier, bounds.
// ----------------------------------------------------------------------------
module psp_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psp_pkg::cfg_t        cfg_i,
  input  psp_pkg::vertex_t     in_data_i,
  input  psp_pkg::psp_cmd_t    cmd_i,
  output psp_pkg::psp_status_t status_o,
  output psp_pkg::result_t     out_data_o
);
  import psp_pkg::*;

  localparam int RemW  = DW + 1;
  localparam int ProdW = COORD_WIDTH + DW;
  localparam int ShW   = ProdW - FRAC_BITS;
  localparam int SumW  = ShW + 1;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic coord_t clamp_sum(input logic signed [SumW-1:0] s);
    logic [SumW-COORD_WIDTH:0] hi;
    hi = s[SumW-1:COORD_WIDTH-1];
    if ((hi == '0) || (hi == '1)) begin
      clamp_sum = s[COORD_WIDTH-1:0];
    end else begin
      clamp_sum = s[SumW-1] ? CoordMin : CoordMax;
    end
  endfunction

  coord_t                  vx_q, vy_q, vz_q;
  logic                    last_q;
  logic signed [DW-1:0]    dx_q, dy_q, dz_q, num_q;
  logic [DvdW-1:0]         dvd_q, q_q;
  logic [DW-1:0]           dvs_q;
  logic [RemW-1:0]         rem_q;
  logic                    neg_q;
  coord_t                  t_q;
  logic signed [ProdW-1:0] prod_q;
  coord_t                  px_q, py_q, pz_q;
  coord_t                  min_x_q, max_x_q, min_z_q, max_z_q;
  result_t                 res_q;

  logic signed [DW-1:0]    lx, lz, ly;
  logic [RemW-1:0]         rem_sh;
  logic [RemW:0]           diff;
  logic                    ge;
  logic signed [DW-1:0]    d_sel;
  coord_t                  v_sel;
  logic signed [ShW-1:0]   sh;
  logic signed [SumW-1:0]  sum;
  coord_t                  p_sat;
  logic                    dy_pos;
  logic                    fault;
  coord_t                  min_x_n, max_x_n, min_z_n, max_z_n;

  assign lx = {cfg_i.light_x[COORD_WIDTH-1], cfg_i.light_x};
  assign ly = {cfg_i.light_y[COORD_WIDTH-1], cfg_i.light_y};
  assign lz = {cfg_i.light_z[COORD_WIDTH-1], cfg_i.light_z};

  assign fault             = (dy_q == '0);
  assign status_o.den_zero = fault;
  // divisor is -dy, so it is negative exactly when dy is positive
  assign dy_pos            = !dy_q[DW-1] && !fault;

  // restoring divider step
  assign rem_sh = {rem_q[RemW-2:0], dvd_q[DvdW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !diff[RemW];

  always_comb begin
    case (cmd_i.axis)
      AXIS_X:  begin d_sel = dx_q; v_sel = vx_q; end
      AXIS_Y:  begin d_sel = dy_q; v_sel = vy_q; end
      AXIS_Z:  begin d_sel = dz_q; v_sel = vz_q; end
      default: begin d_sel = dx_q; v_sel = vx_q; end
    endcase
  end

  // arithmetic shift of the product is floor rounding
  assign sh    = $signed(prod_q[ProdW-1:FRAC_BITS]);
  assign sum   = $signed({sh[ShW-1], sh})
               + $signed({{(SumW-COORD_WIDTH){v_sel[COORD_WIDTH-1]}}, v_sel});
  assign p_sat = clamp_sum(sum);

  // ties also write, harmless
  assign min_x_n = (!fault && (min_x_q >= px_q)) ? px_q : min_x_q;
  assign max_x_n = (!fault && (max_x_q <= px_q)) ? px_q : max_x_q;
  assign min_z_n = (!fault && (min_z_q >= pz_q)) ? pz_q : min_z_q;
  assign max_z_n = (!fault && (max_z_q <= pz_q)) ? pz_q : max_z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      vx_q   <= in_data_i.vertex_x;
      vy_q   <= in_data_i.vertex_y;
      vz_q   <= in_data_i.vertex_z;
      last_q <= in_data_i.last_vertex;
      num_q  <= $signed({in_data_i.vertex_y[COORD_WIDTH-1], in_data_i.vertex_y})
              - $signed({cfg_i.ground_level[COORD_WIDTH-1], cfg_i.ground_level});
      if (cfg_i.directional_mode) begin
        dx_q <= lx;
        dy_q <= ly;
        dz_q <= lz;
      end else begin
        dx_q <= lx - $signed({in_data_i.vertex_x[COORD_WIDTH-1], in_data_i.vertex_x});
        dy_q <= ly - $signed({in_data_i.vertex_y[COORD_WIDTH-1], in_data_i.vertex_y});
        dz_q <= lz - $signed({in_data_i.vertex_z[COORD_WIDTH-1], in_data_i.vertex_z});
      end
    end
    if (cmd_i.div_init) begin
      dvd_q <= {mag(num_q), {FRAC_BITS{1'b0}}};
      dvs_q <= mag(dy_q);
      rem_q <= '0;
      q_q   <= '0;
      neg_q <= num_q[DW-1] ^ dy_pos;
    end
    if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      rem_q <= ge ? diff[RemW-1:0] : rem_sh;
      q_q   <= {q_q[DvdW-2:0], ge};
    end
    if (cmd_i.sat) begin
      if (neg_q) begin
        t_q <= (q_q >= DvdW'($unsigned(CoordMin))) ? CoordMin : -q_q[COORD_WIDTH-1:0];
      end else begin
        t_q <= (q_q > DvdW'($unsigned(CoordMax))) ? CoordMax : q_q[COORD_WIDTH-1:0];
      end
    end
    if (cmd_i.mul) begin
      prod_q <= t_q * d_sel;
    end
    if (cmd_i.acc) begin
      case (cmd_i.axis)
        AXIS_X:  px_q <= p_sat;
        AXIS_Y:  py_q <= p_sat;
        AXIS_Z:  pz_q <= p_sat;
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      res_q.shadow_x     <= fault ? vx_q : px_q;
      res_q.shadow_y     <= fault ? vy_q : py_q;
      res_q.shadow_z     <= fault ? vz_q : pz_q;
      res_q.bound_min_x  <= min_x_n;
      res_q.bound_max_x  <= max_x_n;
      res_q.bound_min_z  <= min_z_n;
      res_q.bound_max_z  <= max_z_n;
      res_q.divide_fault <= fault;
      res_q.mesh_done    <= last_q;
    end
  end

  // running bounds; reseeded after the last vertex of a mesh
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= CoordMax;
      max_x_q <= CoordMin;
      min_z_q <= CoordMax;
      max_z_q <= CoordMin;
    end else if (cmd_i.finish) begin
      min_x_q <= last_q ? CoordMax : min_x_n;
      max_x_q <= last_q ? CoordMin : max_x_n;
      min_z_q <= last_q ? CoordMax : min_z_n;
      max_z_q <= last_q ? CoordMin : max_z_n;
    end
  end

  assign out_data_o = res_q;

endmodule

// ----- hw/rtl/planar_shadow_projection_bounds.sv -----
// ----------------------------------------------------------------------------
// planar_shadow_projection_bounds
// Projects mesh vertices onto the ground plane and tracks X/Z shadow bounds.
// ----------------------------------------------------------------------------
// One vertex is in flight at a time. A vertex with a non-zero divisor goes
// from acceptance to the next acceptance through a setup step, the
// bit-serial restoring divider (one quotient bit per cycle), a saturation
// step, a multiply and an accumulate per axis on the single shared
// multiplier, and the output register load. A vertex whose divisor is zero
// skips the divider and the multiplier. The output register holds a finished
// transaction while the next vertex is being worked on; the block only waits
// at the hand-off if the previous result has still not been taken.
// ----------------------------------------------------------------------------
module planar_shadow_projection_bounds (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psp_pkg::AddrW-1:0]     paddr,
  input  logic [psp_pkg::ApbDataW-1:0]  pwdata,
  output logic [psp_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  psp_pkg::vertex_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output psp_pkg::result_t              out_data_o
);
  import psp_pkg::*;

  cfg_t        cfg;
  psp_cmd_t    cmd;
  psp_status_t status;

  psp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  psp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  psp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

  // a faulting vertex never runs the divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !status.den_zero)
    else $error("divider stepped on zero divisor");

  // no second transaction is taken while one is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while busy");

  // a good projection always lies inside the bounds it reports
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.divide_fault) |->
      (out_data_o.bound_min_x <= out_data_o.shadow_x) &&
      (out_data_o.bound_max_x >= out_data_o.shadow_x) &&
      (out_data_o.bound_min_z <= out_data_o.shadow_z) &&
      (out_data_o.bound_max_z >= out_data_o.shadow_z))
    else $error("shadow outside reported bounds");

  // hand-off loads the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o)
    else $error("finished result not presented");

endmodule

// ----- dv/tb_planar_shadow_projection_bounds.sv -----
// ----------------------------------------------------------------------------
// tb_planar_shadow_projection_bounds
// Self-checking bench: drives vertices under several light and ground settings,
// predicts each projected vertex and running X/Z bounds, and checks every
// result transaction field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_planar_shadow_projection_bounds;
  import psp_pkg::*;

  localparam int unsigned FirstUnmappedIdx = REG_GROUND + 1;
  localparam int unsigned LastUnmappedIdx  = (1 << RegIdxW) - 1;
  localparam int          DrainCycles      = 80;
  localparam int          CycleLimit       = 600000;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [AddrW-1:0]    paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  vertex_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  result_t             out_data_o;

  // mirror of the configuration and the running bounds
  coord_t  lit_x, lit_y, lit_z, gnd;
  logic    dir_mode;
  coord_t  min_x, max_x, min_z, max_z;

  result_t pending_shadows[$];
  int      mismatch_count = 0;
  int      send_idle_pct  = 0;
  int      recv_idle_pct  = 0;
  int      cycle_count    = 0;

  planar_shadow_projection_bounds DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("planar_shadow_projection_bounds verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic coord_t clamp_coord(input longint v);
    if (v > longint'(CoordMax)) return CoordMax;
    if (v < longint'(CoordMin)) return CoordMin;
    return coord_t'(v);
  endfunction

  // (num << FRAC_BITS) / den, truncated toward zero, saturated
  function automatic coord_t ground_quotient(input longint num, input longint den);
    logic [63:0] un, ud, q;
    logic        neg;
    neg = (num < 0) != (den < 0);
    un  = (num < 0) ? 64'(-num) : 64'(num);
    ud  = (den < 0) ? 64'(-den) : 64'(den);
    q   = (un << FRAC_BITS) / ud;
    return clamp_coord(neg ? -longint'(q) : longint'(q));
  endfunction

  // (t * d) >> FRAC_BITS, floor, magnitude capped at 2^(COORD_WIDTH+1)
  function automatic longint scale_q16(input coord_t t, input longint d);
    logic [63:0]  ua, ub;
    logic [127:0] prod, mag_s;
    logic         neg;
    neg   = (t < 0) != (d < 0);
    ua    = (t < 0) ? 64'(-longint'(t)) : 64'(longint'(t));
    ub    = (d < 0) ? 64'(-d) : 64'(d);
    prod  = {64'd0, ua} * {64'd0, ub};
    mag_s = prod >> FRAC_BITS;
    if (neg && (prod[FRAC_BITS-1:0] != '0)) mag_s = mag_s + 128'd1;
    if (mag_s > (128'd1 << (COORD_WIDTH + 1))) mag_s = 128'd1 << (COORD_WIDTH + 1);
    return neg ? -longint'(mag_s[63:0]) : longint'(mag_s[63:0]);
  endfunction

  function automatic void seed_bounds();
    min_x = CoordMax;
    min_z = CoordMax;
    max_x = CoordMin;
    max_z = CoordMin;
  endfunction

  function automatic result_t project_vertex(input vertex_t v);
    result_t r;
    longint  vx, vy, vz, dx, dy, dz, den;
    coord_t  t, px, py, pz;
    vx = longint'(signed'(v.vertex_x));
    vy = longint'(signed'(v.vertex_y));
    vz = longint'(signed'(v.vertex_z));
    if (dir_mode) begin
      dx = longint'(lit_x);
      dy = longint'(lit_y);
      dz = longint'(lit_z);
    end else begin
      dx = longint'(lit_x) - vx;
      dy = longint'(lit_y) - vy;
      dz = longint'(lit_z) - vz;
    end
    den = -dy;
    r.divide_fault = (den == 0);
    if (den == 0) begin
      // vertex passes through, bounds untouched
      px = coord_t'(vx);
      py = coord_t'(vy);
      pz = coord_t'(vz);
    end else begin
      t  = ground_quotient(vy - longint'(gnd), den);
      px = clamp_coord(scale_q16(t, dx) + vx);
      py = clamp_coord(scale_q16(t, dy) + vy);
      pz = clamp_coord(scale_q16(t, dz) + vz);
      if (min_x >= px) min_x = px;
      if (max_x <= px) max_x = px;
      if (min_z >= pz) min_z = pz;
      if (max_z <= pz) max_z = pz;
    end
    r.shadow_x    = px;
    r.shadow_y    = py;
    r.shadow_z    = pz;
    r.bound_min_x = min_x;
    r.bound_max_x = max_x;
    r.bound_min_z = min_z;
    r.bound_max_z = max_z;
    r.mesh_done   = v.last_vertex;
    if (v.last_vertex) seed_bounds();
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [COORD_WIDTH-1:0] want,
                                      input logic [COORD_WIDTH-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void compare_shadow(input result_t want, input result_t got);
    check_field("shadow_x", want.shadow_x, got.shadow_x);
    check_field("shadow_y", want.shadow_y, got.shadow_y);
    check_field("shadow_z", want.shadow_z, got.shadow_z);
    check_field("bound_min_x", want.bound_min_x, got.bound_min_x);
    check_field("bound_max_x", want.bound_max_x, got.bound_max_x);
    check_field("bound_min_z", want.bound_min_z, got.bound_min_z);
    check_field("bound_max_z", want.bound_max_z, got.bound_max_z);
    check_field("divide_fault", COORD_WIDTH'(want.divide_fault), COORD_WIDTH'(got.divide_fault));
    check_field("mesh_done", COORD_WIDTH'(want.mesh_done), COORD_WIDTH'(got.mesh_done));
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pending_shadows.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        compare_shadow(pending_shadows.pop_front(), out_data_o);
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_vertex(input vertex_t v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= v;
    do @(posedge clk_i); while (in_stall_o);
    pending_shadows.push_back(project_vertex(v));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_shadows.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input int unsigned idx, input logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx << AddrLsb);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LIGHT_X:     lit_x = value[COORD_WIDTH-1:0];
      REG_LIGHT_Y:     lit_y = value[COORD_WIDTH-1:0];
      REG_LIGHT_Z:     lit_z = value[COORD_WIDTH-1:0];
      REG_DIRECTIONAL: dir_mode = value[0];
      REG_GROUND:      gnd = value[COORD_WIDTH-1:0];
      default: ;
    endcase
    // bus back to idle before the next transfer
    @(posedge clk_i);
  endtask

  task automatic write_light(input coord_t lx, input coord_t ly, input coord_t lz,
                             input logic mode, input coord_t g);
    write_cfg(REG_LIGHT_X, lx);
    write_cfg(REG_LIGHT_Y, ly);
    write_cfg(REG_LIGHT_Z, lz);
    write_cfg(REG_DIRECTIONAL, ApbDataW'(mode));
    write_cfg(REG_GROUND, g);
  endtask

  function automatic vertex_t vtx(input coord_t x, input coord_t y, input coord_t z,
                                  input logic last);
    vertex_t v;
    v.vertex_x    = x;
    v.vertex_y    = y;
    v.vertex_z    = z;
    v.last_vertex = last;
    return v;
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(4))
      0: return CoordMin;
      1: return CoordMax;
      2: return '0;
      3: return coord_t'(1);
      default: return coord_t'(-1);
    endcase
  endfunction

  // +/-64.0 in Q16.16
  function automatic coord_t scene_coord();
    return coord_t'(int'($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
  endfunction

  function automatic coord_t random_coord(input axis_e axis);
    int r;
    r = $urandom_range(99);
    if (r < 55) return scene_coord();
    if (r < 80) return coord_t'($urandom);
    if (r < 90) return pick_extreme();
    // on the light plane (point-light fault) or on the ground plane
    if (axis == AXIS_Y) return $urandom_range(1) ? lit_y : gnd;
    return scene_coord();
  endfunction

  task automatic random_config();
    coord_t lx, ly, lz, g;
    logic   mode;
    lx   = scene_coord();
    lz   = scene_coord();
    g    = scene_coord();
    mode = 1'b1;
    case ($urandom_range(5))
      0: begin
        lx = '0;
        ly = LightYReset;
        lz = '0;
        g  = '0;
      end
      1: ly = coord_t'(-int'($urandom_range(32'h0008_0000, 32'h0000_4000)));
      2: begin
        mode = 1'b0;
        ly   = coord_t'($urandom_range(32'h0064_0000, 32'h0014_0000));
      end
      3: begin
        lx   = coord_t'($urandom);
        ly   = coord_t'($urandom);
        lz   = coord_t'($urandom);
        g    = coord_t'($urandom);
        mode = 1'($urandom_range(1));
      end
      4: begin
        lx   = pick_extreme();
        ly   = pick_extreme();
        lz   = pick_extreme();
        g    = pick_extreme();
        mode = 1'($urandom_range(1));
      end
      default: ly = '0;
    endcase
    write_light(lx, ly, lz, mode, g);
    if ($urandom_range(3) == 0)
      write_cfg($urandom_range(LastUnmappedIdx, FirstUnmappedIdx), $urandom);
  endtask

  task automatic random_meshes(input int n);
    int   sent;
    int   len;
    logic last;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(10, 1);
      for (int k = 0; k < len; k++) begin
        last = (k == len - 1);
        // odd mesh framing now and then
        if ($urandom_range(99) < 8) last = 1'($urandom_range(1));
        send_vertex(vtx(random_coord(AXIS_X), random_coord(AXIS_Y),
                        random_coord(AXIS_Z), last));
      end
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_default_projection();
    send_vertex(vtx(32'sh0000_0000, 32'sh0001_0000, 32'sh0000_0000, 1'b0));
    send_vertex(vtx(CoordMax, CoordMax, CoordMax, 1'b0));
    send_vertex(vtx(CoordMin, CoordMin, CoordMin, 1'b0));
    send_vertex(vtx(-32'sh0005_8000, 32'sh0003_0000, 32'sh0007_4000, 1'b1));
    send_vertex(vtx(32'sh0000_0001, -32'sh0000_0001, -32'sh0000_0001, 1'b1));
    drain_results();
  endtask

  task automatic test_zero_divisor();
    // flat light: every vertex faults, bounds stay at the seeds
    write_light(32'sh0001_0000, '0, -32'sh0002_0000, 1'b1, '0);
    send_vertex(vtx(32'sh0001_0000, 32'sh0004_0000, 32'sh0002_0000, 1'b0));
    send_vertex(vtx(CoordMin, CoordMax, 32'sh0000_0000, 1'b1));
    drain_results();
    // saturating corner of the quotient and products
    write_light(CoordMax, CoordMin, CoordMin, 1'b1, CoordMax);
    send_vertex(vtx(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0));
    send_vertex(vtx(CoordMin, CoordMin, CoordMax, 1'b0));
    send_vertex(vtx(CoordMax, CoordMax, CoordMin, 1'b1));
    drain_results();
  endtask

  task automatic test_point_light();
    write_light(32'sh0002_0000, 32'sh000a_0000, -32'sh0003_0000, 1'b0, '0);
    send_vertex(vtx(32'sh0001_0000, 32'sh0004_0000, 32'sh0001_0000, 1'b0));
    // vertex level with the light: fault mid-mesh
    send_vertex(vtx(32'sh0001_8000, 32'sh000a_0000, 32'sh0000_8000, 1'b0));
    // same vertex again, ties on the bounds
    send_vertex(vtx(32'sh0001_0000, 32'sh0004_0000, 32'sh0001_0000, 1'b0));
    send_vertex(vtx(-32'sh0003_0000, 32'sh0002_0000, 32'sh0005_0000, 1'b1));
    drain_results();
    // light difference needs the extra bit
    write_light(CoordMin, CoordMin, CoordMin, 1'b0, CoordMin);
    send_vertex(vtx(CoordMax, CoordMax, CoordMax, 1'b0));
    send_vertex(vtx(CoordMax, 32'sh0000_0000, CoordMin, 1'b1));
    drain_results();
  endtask

  task automatic test_unmapped_registers();
    for (int unsigned idx = FirstUnmappedIdx; idx <= LastUnmappedIdx; idx++)
      write_cfg(idx, $urandom);
    send_vertex(vtx(32'sh0000_4000, 32'sh0010_0000, -32'sh0000_4000, 1'b0));
    send_vertex(vtx(-32'sh0000_4000, -32'sh0010_0000, 32'sh0000_4000, 1'b1));
    drain_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
    int done;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    done = 0;
    while (done < n) begin
      random_config();
      random_meshes(50);
      // hold off until every result is back before touching the registers
      drain_results();
      done += 50;
    end
  endtask

  initial begin
    lit_x    = '0;
    lit_y    = LightYReset;
    lit_z    = '0;
    dir_mode = 1'b1;
    gnd      = '0;
    seed_bounds();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 24;
    recv_idle_pct = 74;
    test_default_projection();
    test_zero_divisor();
    test_point_light();
    test_unmapped_registers();

    test_random_traffic(24, 74, 200);
    test_random_traffic(74, 24, 200);
    test_random_traffic(0, 0, 200);

    if (mismatch_count == 0) begin
      $display("planar_shadow_projection_bounds verification clean");
    end else begin
      $display("planar_shadow_projection_bounds verification failed");
    end
    $finish;
  end

endmodule
